>>> hdl/assert_macros.svh
// assertion macros shared by the serial clock prescaler selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// implication checked in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/spi_ps_pkg.sv
// types and constants of the serial clock prescaler selector
package spi_ps_pkg;

    localparam int CTL_W   = 16;
    localparam int DIV_W   = 26;
    localparam int NUM_W   = 32;
    localparam int TOUT_W  = 12;
    localparam int SEC_W   = 4;

    // control word bits kept from the input
    localparam logic [CTL_W-1:0] CTL_KEEP_MASK = 16'hFFE0;

    // ratio limits for the primary prescaler choice
    localparam logic [NUM_W-1:0] LIMIT_P1  = 32'd512;
    localparam logic [NUM_W-1:0] LIMIT_P4  = 32'd2051;
    localparam logic [NUM_W-1:0] LIMIT_P16 = 32'd8207;

    // ratio limits for the secondary prescaler choice
    localparam logic [NUM_W-1:0] SEC_SAT_LIMIT = 32'd448;
    localparam logic [NUM_W-1:0] SEC_ONE_LIMIT = 32'd64;
    localparam logic [SEC_W-1:0] SEC_MAX       = 4'd8;
    localparam logic [SEC_W-1:0] SEC_MIN       = 4'd1;

    // primary prescaler codes
    localparam logic [1:0] PCODE_DIV1  = 2'd3;
    localparam logic [1:0] PCODE_DIV4  = 2'd2;
    localparam logic [1:0] PCODE_DIV16 = 2'd1;
    localparam logic [1:0] PCODE_DIV64 = 2'd0;

    // one item travelling through the divider cells
    typedef struct packed {
        logic [CTL_W-1:0] ctl;
        logic [DIV_W-1:0] div;
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic             err;
    } t_div;

    // finished result
    typedef struct packed {
        logic [CTL_W-1:0]  ctl;
        logic [TOUT_W-1:0] timeout;
        logic              err;
    } t_result;

endpackage

>>> hdl/spi_ps_cell.sv
// one restoring division cell: one quotient bit per cell, with its own stall control
module spi_ps_cell
    import spi_ps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_ready,
    output logic o_valid,
    output t_div o_data,
    input  logic i_ready
);

    logic          r_valid;
    t_div          r_data;
    t_div          n_data;
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic          ge;

    // cell takes a new item when empty or when its item moves on
    assign o_ready = !r_valid || i_ready;

    // shift in the next dividend bit and try the subtraction
    always_comb begin
        trial  = {i_data.rem, i_data.num[NUM_W-1]};
        diff   = trial - {1'b0, i_data.div};
        ge     = (trial >= {1'b0, i_data.div});
        n_data = i_data;
        n_data.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_data.num = {i_data.num[NUM_W-2:0], 1'b0};
        n_data.quo = {i_data.quo[NUM_W-2:0], ge};
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/spi_ps_encode.sv
// maps the divide ratio to prescaler codes, control word and poll timeout
module spi_ps_encode
    import spi_ps_pkg::*;
(
    input  t_div    i_data,
    output t_result o_result
);

    logic [NUM_W-1:0]  q;
    logic [NUM_W-1:0]  scaled;
    logic [1:0]        pcode;
    logic [3:0]        shamt;
    logic [SEC_W-1:0]  sec;
    logic [9:0]        sec_sum;
    logic [TOUT_W-1:0] tout;

    always_comb begin
        q = i_data.quo;

        // primary prescaler: smallest with ratio of 512 or less, else divide by 64
        if (q <= LIMIT_P1) begin
            pcode  = PCODE_DIV1;
            shamt  = 4'd2;
            scaled = q;
        end else if (q <= LIMIT_P4) begin
            pcode  = PCODE_DIV4;
            shamt  = 4'd4;
            scaled = q >> 2;
        end else if (q <= LIMIT_P16) begin
            pcode  = PCODE_DIV16;
            shamt  = 4'd6;
            scaled = q >> 4;
        end else begin
            pcode  = PCODE_DIV64;
            shamt  = 4'd8;
            scaled = q >> 6;
        end

        // secondary prescaler: ceiling of scaled ratio over 64, from 1 to 8
        sec_sum = {1'b0, scaled[8:0]} + 10'd63;
        if (scaled > SEC_SAT_LIMIT) begin
            sec = SEC_MAX;
        end else if (scaled > SEC_ONE_LIMIT) begin
            sec = SEC_W'(sec_sum >> 6);
        end else begin
            sec = SEC_MIN;
        end

        // primary times secondary times four as a shift
        tout = TOUT_W'(sec) << shamt;

        if (i_data.err) begin
            o_result.ctl     = '0;
            o_result.timeout = '0;
            o_result.err     = 1'b1;
        end else begin
            o_result.ctl     = (i_data.ctl & CTL_KEEP_MASK)
                             | {11'd0, 3'(SEC_MAX - sec), pcode};
            o_result.timeout = tout;
            o_result.err     = 1'b0;
        end
    end

endmodule

>>> hdl/spi_prescaler_select_top.sv
// top level of the serial clock prescaler selector
// Picks primary and secondary serial clock prescalers from a core clock and
// a wanted bit rate.
// Input channel (s side): one transfer carries control word, wanted rate and
// core clock. Output channel (m side): one transfer per input carries the
// control word with prescaler codes in bits 4:0 and the poll timeout in
// tdata, and the zero-rate error flag in tuser.
// The ratio clock*64/rate comes from a row of 32 restoring division cells,
// one quotient bit per cell, followed by an output register holding the
// encoded result, so each item passes the cell registers in order and then
// the output register before it appears on the output.
// A new item is accepted every cycle while input ready is high; the cells set
// that rate, each taking an item only when empty or when its own item moves on.
// When the receiver stalls, the output register holds its result and the
// cells behind it keep filling empty slots; input ready drops only once
// every cell and the output register are full.
// Reset (synchronous, active low) empties all cells and the output register.
// There is no kept state between items.
`include "assert_macros.svh"
module spi_prescaler_select_top
    import spi_ps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // control_word_in, wanted_rate, core_clock, pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // control_word_out, poll_timeout, pad
    output logic        o_m_tuser   // rate_error
);

    localparam int CELLS = NUM_W;

    logic    cell_valid [CELLS+1];
    logic    cell_ready [CELLS+1];
    t_div    cell_data  [CELLS+1];
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    out_ready;

    // load the first cell from the input transfer
    always_comb begin
        cell_data[0].ctl = i_s_tdata[15:0];
        cell_data[0].div = i_s_tdata[41:16];
        cell_data[0].rem = '0;
        cell_data[0].num = {i_s_tdata[67:42], 6'd0};
        cell_data[0].quo = '0;
        cell_data[0].err = (i_s_tdata[41:16] == '0);
    end
    assign cell_valid[0] = i_s_tvalid;
    assign o_s_tready    = cell_ready[0];

    // row of division cells
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        spi_ps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .i_data  (cell_data[g]),
            .o_ready (cell_ready[g]),
            .o_valid (cell_valid[g+1]),
            .o_data  (cell_data[g+1]),
            .i_ready (cell_ready[g+1])
        );
    end

    // encode the finished ratio
    spi_ps_encode u_encode (
        .i_data   (cell_data[CELLS]),
        .o_result (result)
    );

    // output register
    assign out_ready         = !r_out_valid || i_m_tready;
    assign cell_ready[CELLS] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= cell_valid[CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && cell_valid[CELLS]) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out.timeout, r_out.ctl};
    assign o_m_tuser  = r_out.err;

    // checks
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == '0)
    `ASSERT_IMPLY(a_tout_nonzero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[27:16] != '0)
    `ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)

endmodule

>>> dv/testbench.sv
// testbench for the serial clock prescaler selector: directed table, then random traffic
module testbench;
    import spi_ps_pkg::*;

    // one directed stimulus row, with an optional hand-written result
    typedef struct packed {
        logic [15:0] ctl;
        logic [25:0] rate;
        logic [25:0] clk;
        logic        typed;
        t_result     want;
    } t_stim_row;

    localparam int N_DIR = 22;
    localparam int N_PER_PHASE = 375;
    localparam int N_BOUND = 10;
    localparam int SRC_IDLE [4] = '{0, 80, 0, 12};
    localparam int SNK_STALL [4] = '{0, 0, 80, 12};
    localparam int BOUND_RATIO [N_BOUND] = '{64, 65, 448, 449, 512, 513, 2051, 2052, 8207, 8208};
    localparam t_result NO_WANT = '{16'h0000, 12'd0, 1'b0};

    // boundary ratios use rate 64 so that the ratio equals the clock
    localparam t_stim_row DIR_ROWS [N_DIR] = '{
        '{16'hFFFF, 26'd0, 26'h3FFFFFF, 1'b1, '{16'h0000, 12'd0, 1'b1}},
        '{16'h0000, 26'd0, 26'd0, 1'b1, '{16'h0000, 12'd0, 1'b1}},
        '{16'hFFFF, 26'h3FFFFFF, 26'd0, 1'b1, '{16'hFFFF, 12'd4, 1'b0}},
        '{16'h0000, 26'd1, 26'd0, 1'b1, '{16'h001F, 12'd4, 1'b0}},
        '{16'h0000, 26'd1, 26'h3FFFFFF, 1'b1, '{16'h0000, 12'd2048, 1'b0}},
        '{16'hFFFF, 26'd1, 26'h3FFFFFF, 1'b1, '{16'hFFE0, 12'd2048, 1'b0}},
        '{16'hAAAA, 26'h3FFFFFF, 26'h3FFFFFF, 1'b0, NO_WANT},
        '{16'h5555, 26'd64, 26'd512, 1'b0, NO_WANT},
        '{16'h1234, 26'd64, 26'd513, 1'b0, NO_WANT},
        '{16'h8001, 26'd64, 26'd2051, 1'b0, NO_WANT},
        '{16'h4002, 26'd64, 26'd2052, 1'b0, NO_WANT},
        '{16'h2004, 26'd64, 26'd8207, 1'b0, NO_WANT},
        '{16'h1008, 26'd64, 26'd8208, 1'b0, NO_WANT},
        '{16'h0810, 26'd64, 26'd64, 1'b0, NO_WANT},
        '{16'h0420, 26'd64, 26'd65, 1'b0, NO_WANT},
        '{16'h0240, 26'd64, 26'd448, 1'b0, NO_WANT},
        '{16'h0180, 26'd64, 26'd449, 1'b0, NO_WANT},
        '{16'h001F, 26'd64, 26'd128, 1'b0, NO_WANT},
        '{16'hFFE0, 26'd64, 26'd129, 1'b0, NO_WANT},
        '{16'h0020, 26'd3, 26'd1000, 1'b0, NO_WANT},
        '{16'h8000, 26'h2000000, 26'h2000000, 1'b0, NO_WANT},
        '{16'h7FFF, 26'h1555555, 26'h2AAAAAA, 1'b0, NO_WANT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    // what the driver attaches to the transfer in flight
    logic        cur_typed = 1'b0;
    t_result     cur_want = '0;

    t_result     pending_results [$];
    t_result     seen;
    t_result     oldest;
    int          mismatch_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;

    spi_prescaler_select_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // expected settings for one request
    function automatic t_result prescale_of(input logic [15:0] ctl, input logic [25:0] rate,
                                            input logic [25:0] clk);
        logic [31:0] ratio;
        logic [1:0]  pcode;
        int unsigned prim;
        int unsigned sec;
        t_result     r;
        r = '0;
        if (rate == '0) begin
            r.err = 1'b1;
            return r;
        end
        ratio = {clk, 6'b000000} / {6'b000000, rate};
        // smallest primary that brings the ratio to 512 or below, else 64
        if (ratio <= 32'd512) begin
            prim = 1;
            pcode = PCODE_DIV1;
        end else if ((ratio >> 2) <= 32'd512) begin
            prim = 4;
            pcode = PCODE_DIV4;
            ratio = ratio >> 2;
        end else if ((ratio >> 4) <= 32'd512) begin
            prim = 16;
            pcode = PCODE_DIV16;
            ratio = ratio >> 4;
        end else begin
            prim = 64;
            pcode = PCODE_DIV64;
            ratio = ratio >> 6;
        end
        // secondary in steps of 64, saturating at 8
        if (ratio > 32'd448) begin
            sec = 8;
        end else if (ratio > 32'd64) begin
            sec = (ratio + 63) / 64;
        end else begin
            sec = 1;
        end
        r.ctl = {ctl[15:5], 3'(8 - sec), pcode};
        r.timeout = 12'(prim * sec * 4);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // one transfer on the input side, with random gaps ahead of it
    task automatic send_request(input logic [15:0] ctl, input logic [25:0] rate,
                                input logic [25:0] clk, input logic typed, input t_result want);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, clk, rate, ctl};
        cur_typed <= typed;
        cur_want <= want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // hold the sender off until every pending result is back
    task automatic drain;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // random request: wide spread of ratios, some aimed at the thresholds
    task automatic pick_request(output logic [15:0] ctl, output logic [25:0] rate,
                                output logic [25:0] clk);
        int unsigned w;
        int unsigned k;
        int unsigned target;
        ctl = 16'($urandom);
        case ($urandom_range(3))
            0: begin
                rate = 26'($urandom);
                clk = 26'($urandom);
            end
            3: begin
                k = $urandom_range(4095, 1);
                if ($urandom_range(1)) target = BOUND_RATIO[$urandom_range(N_BOUND - 1)];
                else target = $urandom_range(8300);
                rate = 26'(k * 64);
                clk = 26'(target * k + $urandom_range(k - 1));
            end
            default: begin
                w = $urandom_range(26);
                rate = 26'($urandom) & ((w == 0) ? 26'd0 : ({26{1'b1}} >> (26 - w)));
                w = $urandom_range(26);
                clk = 26'($urandom) & ((w == 0) ? 26'd0 : ({26{1'b1}} >> (26 - w)));
            end
        endcase
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // result check first, then the new expectation, all on one edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                seen = '{o_m_tdata[15:0], o_m_tdata[27:16], o_m_tuser};
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected transfer", 32'(seen), 32'd0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (seen.ctl !== oldest.ctl)
                        flag_mismatch("control_word_out", 32'(seen.ctl), 32'(oldest.ctl));
                    if (seen.timeout !== oldest.timeout)
                        flag_mismatch("poll_timeout", 32'(seen.timeout), 32'(oldest.timeout));
                    if (seen.err !== oldest.err)
                        flag_mismatch("rate_error", 32'(seen.err), 32'(oldest.err));
                end
            end
            if (s_tvalid && o_s_tready) begin
                if (cur_typed) pending_results.push_back(cur_want);
                else pending_results.push_back(prescale_of(s_tdata[15:0], s_tdata[41:16],
                                                           s_tdata[67:42]));
            end
        end
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

    // stimulus
    initial begin
        logic [15:0] ctl;
        logic [25:0] rate;
        logic [25:0] clk;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            send_request(DIR_ROWS[i].ctl, DIR_ROWS[i].rate, DIR_ROWS[i].clk,
                         DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        drain();

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = SRC_IDLE[ph];
            snk_stall_pct = SNK_STALL[ph];
            for (int n = 0; n < N_PER_PHASE; n++) begin
                pick_request(ctl, rate, clk);
                send_request(ctl, rate, clk, 1'b0, NO_WANT);
            end
            drain();
        end

        // anything late or extra shows up here
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
